@@ sv/cfkb_pkg.sv @@
// Shared types and constants for the clipped fill and keyed blit engine.
// Used by the controller, the datapath and the top level; no dependencies.
package cfkb_pkg;

    // Field and arithmetic widths fixed by the command format.
    localparam int DIM_BITS       = 8;
    localparam int COORD_BITS     = 20;
    localparam int FIELD_BITS     = 16;
    localparam int COLOR_BITS     = 32;
    localparam int IN_DATA_BITS   = 6 * FIELD_BITS + COLOR_BITS;
    localparam int OUT_DATA_BITS  = COLOR_BITS + 2 * DIM_BITS;
    localparam int CFG_ADDR_BITS  = 2;

    // Defaults for the top-level parameters.
    localparam int DEF_MAX_WIDTH  = 128;
    localparam int DEF_MAX_HEIGHT = 128;
    localparam int DEF_PIXEL_BITS = 32;

    // Command codes.
    typedef enum logic [2:0] {
        ACT_WRITE    = 3'd0,
        ACT_READ     = 3'd1,
        ACT_FILL     = 3'd2,
        ACT_FILL_ALL = 3'd3,
        ACT_COPY     = 3'd4
    } action_t;

    // Configuration register indexes.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_SURFACE_WIDTH  = 2'd0,
        REG_SURFACE_HEIGHT = 2'd1,
        REG_USE_COLOR_KEY  = 2'd2,
        REG_KEY_COLOR      = 2'd3
    } cfg_index_t;

    // Controller states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_CLIP_A,
        S_CLIP_B,
        S_CLIP_C,
        S_CLIP_D,
        S_CLIP_E,
        S_START,
        S_PIX,
        S_PIX_WAIT,
        S_FILL,
        S_COPY_RD,
        S_COPY_WR,
        S_RESULT
    } state_t;

    // Datapath operation issued by the controller each cycle.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_CLIP_A,
        OP_CLIP_B,
        OP_CLIP_C,
        OP_CLIP_D,
        OP_CLIP_E,
        OP_START,
        OP_PIX,
        OP_FILL,
        OP_COPY_RD,
        OP_COPY_WR,
        OP_RESULT
    } dp_op_t;

    // Status returned from the datapath to the controller.
    typedef struct packed {
        action_t act;
        logic    pix_ok;
        logic    clip_ok;
        logic    last;
        logic    out_free;
    } dp_status_t;

endpackage

@@ sv/cfkb_ctrl.sv @@
// Command sequencer for the blit engine: steps through clipping, the pixel
// loops and result delivery. Depends on cfkb_pkg.
module cfkb_ctrl
    import cfkb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  dp_status_t status,
    output dp_op_t     op
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and datapath operation.
    always_comb
    begin
        state_next = state_reg;
        op         = OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    op         = OP_LOAD;
                    state_next = S_CLIP_A;
                end
            end
            S_CLIP_A:
            begin
                op = OP_CLIP_A;
                case (status.act)
                    ACT_WRITE, ACT_READ:
                    begin
                        state_next = status.pix_ok ? S_PIX : S_RESULT;
                    end
                    ACT_FILL_ALL: state_next = S_START;
                    ACT_FILL, ACT_COPY: state_next = S_CLIP_B;
                    default: state_next = S_RESULT;
                endcase
            end
            S_CLIP_B:
            begin
                op         = OP_CLIP_B;
                state_next = S_CLIP_C;
            end
            S_CLIP_C:
            begin
                op         = OP_CLIP_C;
                state_next = (status.act == ACT_COPY) ? S_CLIP_D : S_START;
            end
            S_CLIP_D:
            begin
                op         = OP_CLIP_D;
                state_next = S_CLIP_E;
            end
            S_CLIP_E:
            begin
                op         = OP_CLIP_E;
                state_next = S_START;
            end
            S_START:
            begin
                op = OP_START;
                if (!status.clip_ok)
                begin
                    state_next = S_RESULT;
                end
                else if (status.act == ACT_COPY)
                begin
                    state_next = S_COPY_RD;
                end
                else
                begin
                    state_next = S_FILL;
                end
            end
            S_PIX:
            begin
                op         = OP_PIX;
                state_next = (status.act == ACT_READ) ? S_PIX_WAIT : S_RESULT;
            end
            S_PIX_WAIT:
            begin
                state_next = S_RESULT;
            end
            S_FILL:
            begin
                op = OP_FILL;
                if (status.last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_COPY_RD:
            begin
                op         = OP_COPY_RD;
                state_next = S_COPY_WR;
            end
            S_COPY_WR:
            begin
                op         = OP_COPY_WR;
                state_next = status.last ? S_RESULT : S_COPY_RD;
            end
            S_RESULT:
            begin
                if (status.out_free)
                begin
                    op         = OP_RESULT;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

endmodule

@@ sv/cfkb_datapath.sv @@
// Datapath of the blit engine: configuration registers, clipping arithmetic,
// loop counters, the frame store and the result register. Depends on cfkb_pkg.
module cfkb_datapath
    import cfkb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COLOR_BITS-1:0]    cfg_wdata,
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    input  logic [2:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    output logic                     m_tuser,
    input  dp_op_t                   op,
    output dp_status_t               status
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    // Configuration registers.
    logic [DIM_BITS-1:0]   surface_width_reg;
    logic [DIM_BITS-1:0]   surface_height_reg;
    logic                  use_color_key_reg;
    logic [COLOR_BITS-1:0] key_color_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            surface_width_reg  <= DIM_BITS'(128);
            surface_height_reg <= DIM_BITS'(128);
            use_color_key_reg  <= 1'b0;
            key_color_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_addr))
                REG_SURFACE_WIDTH:  surface_width_reg  <= cfg_wdata[DIM_BITS-1:0];
                REG_SURFACE_HEIGHT: surface_height_reg <= cfg_wdata[DIM_BITS-1:0];
                REG_USE_COLOR_KEY:  use_color_key_reg  <= cfg_wdata[0];
                REG_KEY_COLOR:      key_color_reg      <= cfg_wdata;
                default:            use_color_key_reg  <= use_color_key_reg;
            endcase
        end
    end

    // Surface size in use, capped at the store size.
    logic [DIM_BITS-1:0] surf_w;
    logic [DIM_BITS-1:0] surf_h;
    coord_t              sw;
    coord_t              sh;

    assign surf_w = (int'(surface_width_reg) > MAX_WIDTH) ? DIM_BITS'(MAX_WIDTH)
                                                          : surface_width_reg;
    assign surf_h = (int'(surface_height_reg) > MAX_HEIGHT) ? DIM_BITS'(MAX_HEIGHT)
                                                            : surface_height_reg;
    assign sw = $signed({{(COORD_BITS-DIM_BITS){1'b0}}, surf_w});
    assign sh = $signed({{(COORD_BITS-DIM_BITS){1'b0}}, surf_h});

    // Command registers.
    action_t               act_reg, act_next;
    coord_t                cx_reg, cx_next;
    coord_t                cy_reg, cy_next;
    coord_t                cw_reg, cw_next;
    coord_t                ch_reg, ch_next;
    coord_t                csx_reg, csx_next;
    coord_t                csy_reg, csy_next;
    logic [PIXEL_BITS-1:0] color_reg, color_next;
    logic                  guard_reg, guard_next;
    logic                  down_reg, down_next;
    logic                  fwd_reg, fwd_next;
    logic [DIM_BITS-1:0]   row_reg, row_next;
    logic [DIM_BITS-1:0]   col_reg, col_next;

    // Result register.
    logic                  out_valid_reg, out_valid_next;
    logic [COLOR_BITS-1:0] out_pixel_reg, out_pixel_next;
    logic [DIM_BITS-1:0]   out_w_reg, out_w_next;
    logic [DIM_BITS-1:0]   out_h_reg, out_h_next;
    logic                  out_empty_reg, out_empty_next;

    // Frame store.
    logic [PIXEL_BITS-1:0] mem [DEPTH];
    logic [PIXEL_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;
    logic [AW-1:0]         mem_waddr;
    logic [AW-1:0]         mem_raddr;
    logic [PIXEL_BITS-1:0] mem_wdata;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

    // Row-major address of a pixel.
    function automatic logic [AW-1:0] pix_addr(input logic [DIM_BITS-1:0] row,
                                               input logic [DIM_BITS-1:0] col,
                                               input logic [DIM_BITS-1:0] stride);
        logic [2*DIM_BITS-1:0] prod;
        logic [2*DIM_BITS:0]   sum;
        prod = row * stride;
        sum  = {1'b0, prod} + {{(DIM_BITS+1){1'b0}}, col};
        return AW'(sum);
    endfunction

    // Loop position, walked in the required row and column directions.
    logic [DIM_BITS-1:0] cw8;
    logic [DIM_BITS-1:0] ch8;
    logic [DIM_BITS-1:0] line;
    logic [DIM_BITS-1:0] pcol;
    logic [AW-1:0]       dst_addr;
    logic [AW-1:0]       src_addr;
    logic                last_col;
    logic                last;

    assign cw8      = cw_reg[DIM_BITS-1:0];
    assign ch8      = ch_reg[DIM_BITS-1:0];
    assign line     = down_reg ? row_reg : (ch8 - 1'b1 - row_reg);
    assign pcol     = fwd_reg ? col_reg : (cw8 - 1'b1 - col_reg);
    assign dst_addr = pix_addr(cy_reg[DIM_BITS-1:0] + line,
                               cx_reg[DIM_BITS-1:0] + pcol, surf_w);
    assign src_addr = pix_addr(csy_reg[DIM_BITS-1:0] + line,
                               csx_reg[DIM_BITS-1:0] + pcol, surf_w);
    assign last_col = (col_reg == cw8 - 1'b1);
    assign last     = last_col && (row_reg == ch8 - 1'b1);

    // Status toward the controller.
    logic pix_ok;
    logic clip_ok;
    logic is_pixel;
    logic is_area;
    logic done;
    logic key_hit;

    assign pix_ok   = (cx_reg >= 0) && (cy_reg >= 0) && (cx_reg < sw) && (cy_reg < sh);
    assign clip_ok  = guard_reg && (cw_reg > 0) && (ch_reg > 0);
    assign is_pixel = (act_reg == ACT_WRITE) || (act_reg == ACT_READ);
    assign is_area  = (act_reg == ACT_FILL) || (act_reg == ACT_FILL_ALL)
                   || (act_reg == ACT_COPY);
    assign done     = is_pixel ? pix_ok : (is_area && clip_ok);
    assign key_hit  = use_color_key_reg && (rd_data_reg == key_color_reg[PIXEL_BITS-1:0]);

    assign status.act      = act_reg;
    assign status.pix_ok   = pix_ok;
    assign status.clip_ok  = clip_ok;
    assign status.last     = last;
    assign status.out_free = !out_valid_reg || m_tready;

    // Next values for the command, loop and result registers.
    always_comb
    begin
        act_next       = act_reg;
        cx_next        = cx_reg;
        cy_next        = cy_reg;
        cw_next        = cw_reg;
        ch_next        = ch_reg;
        csx_next       = csx_reg;
        csy_next       = csy_reg;
        color_next     = color_reg;
        guard_next     = guard_reg;
        down_next      = down_reg;
        fwd_next       = fwd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        out_pixel_next = out_pixel_reg;
        out_w_next     = out_w_reg;
        out_h_next     = out_h_reg;
        out_empty_next = out_empty_reg;
        out_valid_next = (out_valid_reg && m_tready) ? 1'b0 : out_valid_reg;
        mem_we         = 1'b0;
        mem_re         = 1'b0;
        mem_waddr      = dst_addr;
        mem_raddr      = src_addr;
        mem_wdata      = color_reg;
        case (op)
            OP_LOAD:
            begin
                act_next   = action_t'(s_tuser);
                cx_next    = COORD_BITS'($signed(s_tdata[15:0]));
                cy_next    = COORD_BITS'($signed(s_tdata[31:16]));
                cw_next    = COORD_BITS'($signed(s_tdata[47:32]));
                ch_next    = COORD_BITS'($signed(s_tdata[63:48]));
                csx_next   = COORD_BITS'($signed(s_tdata[79:64]));
                csy_next   = COORD_BITS'($signed(s_tdata[95:80]));
                color_next = s_tdata[96 +: PIXEL_BITS];
                down_next  = 1'b1;
                fwd_next   = 1'b1;
                row_next   = '0;
                col_next   = '0;
            end
            OP_CLIP_A:
            begin
                guard_next = !((cx_reg > sw) || (cy_reg > sh));
                if (act_reg == ACT_COPY)
                begin
                    guard_next = guard_next && (sw > 0) && (sh > 0);
                    if (cw_reg > sw)
                    begin
                        cw_next = sw;
                    end
                    if (ch_reg > sh)
                    begin
                        ch_next = sh;
                    end
                end
                else if (act_reg == ACT_FILL_ALL)
                begin
                    guard_next = 1'b1;
                    cx_next    = '0;
                    cy_next    = '0;
                    cw_next    = sw;
                    ch_next    = sh;
                end
            end
            OP_CLIP_B:
            begin
                // A negative destination origin trims and moves the source.
                if (cy_reg < 0)
                begin
                    csy_next = csy_reg - cy_reg;
                    ch_next  = ch_reg + cy_reg;
                    cy_next  = '0;
                end
                if (cx_reg < 0)
                begin
                    csx_next = csx_reg - cx_reg;
                    cw_next  = cw_reg + cx_reg;
                    cx_next  = '0;
                end
            end
            OP_CLIP_C:
            begin
                if (cx_reg + cw_reg > sw)
                begin
                    cw_next = sw - cx_reg;
                end
                if (cy_reg + ch_reg > sh)
                begin
                    ch_next = sh - cy_reg;
                end
            end
            OP_CLIP_D:
            begin
                // A negative source origin trims and moves the destination.
                if (csx_reg < 0)
                begin
                    cx_next  = cx_reg - csx_reg;
                    cw_next  = cw_reg + csx_reg;
                    csx_next = '0;
                end
                if (csy_reg < 0)
                begin
                    cy_next  = cy_reg - csy_reg;
                    ch_next  = ch_reg + csy_reg;
                    csy_next = '0;
                end
            end
            OP_CLIP_E:
            begin
                if (csx_reg + cw_reg > sw)
                begin
                    cw_next = sw - csx_reg;
                end
                if (csy_reg + ch_reg > sh)
                begin
                    ch_next = sh - csy_reg;
                end
            end
            OP_START:
            begin
                // Overlapping copies walk away from the area they overwrite.
                row_next = '0;
                col_next = '0;
                if (act_reg == ACT_COPY)
                begin
                    down_next = (csy_reg >= cy_reg);
                    fwd_next  = (csy_reg > cy_reg) || ((csy_reg == cy_reg) && (csx_reg > cx_reg));
                end
                else
                begin
                    down_next = 1'b1;
                    fwd_next  = 1'b1;
                end
            end
            OP_PIX:
            begin
                mem_raddr = dst_addr;
                if (act_reg == ACT_WRITE)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_re = 1'b1;
                end
            end
            OP_FILL, OP_COPY_WR:
            begin
                if (op == OP_FILL)
                begin
                    mem_we = 1'b1;
                end
                else
                begin
                    mem_we    = !key_hit;
                    mem_wdata = rd_data_reg;
                end
                if (last_col)
                begin
                    col_next = '0;
                    row_next = row_reg + 1'b1;
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
            end
            OP_COPY_RD:
            begin
                mem_re = 1'b1;
            end
            OP_RESULT:
            begin
                out_valid_next = 1'b1;
                out_empty_next = !done;
                out_pixel_next = (done && (act_reg == ACT_READ))
                               ? COLOR_BITS'(rd_data_reg) : '0;
                if (!done)
                begin
                    out_w_next = '0;
                    out_h_next = '0;
                end
                else if (is_pixel)
                begin
                    out_w_next = DIM_BITS'(1);
                    out_h_next = DIM_BITS'(1);
                end
                else
                begin
                    out_w_next = cw8;
                    out_h_next = ch8;
                end
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg       <= act_next;
        cx_reg        <= cx_next;
        cy_reg        <= cy_next;
        cw_reg        <= cw_next;
        ch_reg        <= ch_next;
        csx_reg       <= csx_next;
        csy_reg       <= csy_next;
        color_reg     <= color_next;
        guard_reg     <= guard_next;
        down_reg      <= down_next;
        fwd_reg       <= fwd_next;
        row_reg       <= row_next;
        col_reg       <= col_next;
        out_pixel_reg <= out_pixel_next;
        out_w_reg     <= out_w_next;
        out_h_reg     <= out_h_next;
        out_empty_reg <= out_empty_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_h_reg, out_w_reg, out_pixel_reg};
    assign m_tuser  = out_empty_reg;

endmodule

@@ sv/clipped_fill_and_keyed_blit.sv @@
// Top level of the clipped fill and keyed blit engine.
// Instantiates cfkb_ctrl and cfkb_datapath; depends on cfkb_pkg.
//
// Usage: commands arrive as words on the s_ group, one result word per command
// leaves on the m_ group. Registers are to be written through cfg_we/cfg_addr/cfg_wdata
// only while no command is in flight, a rule on the user that the block does not
// enforce. A command word is taken only when the engine is idle; one command is
// worked on at a time. Each copied pixel is read and then written through the
// single frame store. The next command can be taken in the cycle after the
// result is loaded.
// The frame store write port sets the fill rate of one pixel per cycle.
// Reset clears the controller, the result valid flag and the configuration
// registers (128 x 128 surface, key off, key color 0); the frame store is not
// cleared and must be filled before it is read.
// The result sits in an output register: while the receiver stalls, the
// engine still accepts and works on the next command and only waits, when
// that command finishes, for the register to be taken.
module clipped_fill_and_keyed_blit
    import cfkb_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [COLOR_BITS-1:0]    cfg_wdata,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    // dst_x, dst_y, rect_width, rect_height, src_x, src_y, fill_color
    input  logic [IN_DATA_BITS-1:0]  s_tdata,
    // action
    input  logic [2:0]               s_tuser,
    output logic                     m_tvalid,
    input  logic                     m_tready,
    // read_pixel, clipped_width, clipped_height
    output logic [OUT_DATA_BITS-1:0] m_tdata,
    // empty_clip
    output logic                     m_tuser
);

    dp_op_t     op;
    dp_status_t status;

    // Command sequencer.
    cfkb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .op       (op)
    );

    // Clipping, counters and frame store.
    cfkb_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .PIXEL_BITS (PIXEL_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .op        (op),
        .status    (status)
    );

endmodule
